/* hdl/ldc_pkg.sv */
`timescale 1ns / 1ps

package ldc_pkg;

  localparam int unsigned MotorTimeoutSeconds = 100;
  localparam int unsigned SecsPerMinute       = 60;
  localparam int unsigned BattHysteresis      = 5;

  localparam int unsigned LevelW   = 12;
  localparam int unsigned QualW    = 8;
  localparam int unsigned DelayW   = 10;
  localparam int unsigned SecW     = 17;
  localparam int unsigned DuskW    = 16;
  localparam int unsigned PctW     = 7;
  localparam int unsigned TimerW   = 7;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 17;
  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 8;

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_OPEN_BRIGHT  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_CLOSE_BRIGHT = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_QUALIFY      = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_CLOSE_DELAY  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_LAMP_SECS    = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_FIRST_LAMP   = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_BATT_WARN    = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_MANUAL       = 3'd7;

  // motor phase
  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_CLOSE  = 2'd1;
  localparam logic [1:0] PH_UNWIND = 2'd2;
  localparam logic [1:0] PH_OPEN   = 2'd3;

  // motor drive codes
  localparam logic [1:0] DRV_RELEASE  = 2'd0;
  localparam logic [1:0] DRV_FORWARD  = 2'd1;
  localparam logic [1:0] DRV_BACKWARD = 2'd2;
  localparam logic [1:0] DRV_ILLEGAL  = 2'd3;

  // event codes
  localparam logic [2:0] EV_NONE        = 3'd0;
  localparam logic [2:0] EV_DUSK        = 3'd1;
  localparam logic [2:0] EV_CLOSED      = 3'd2;
  localparam logic [2:0] EV_CLOSE_FAIL  = 3'd3;
  localparam logic [2:0] EV_OPENED      = 3'd4;
  localparam logic [2:0] EV_OPEN_FAIL   = 3'd5;
  localparam logic [2:0] EV_BATTERY_LOW = 3'd6;
  localparam logic [2:0] EV_ILLEGAL     = 3'd7;

  typedef struct packed {
    logic [LevelW-1:0] open_brightness;
    logic [LevelW-1:0] close_brightness;
    logic [QualW-1:0]  qualify_seconds;
    logic [DelayW-1:0] close_delay_minutes;
    logic [SecW-1:0]   lamp_seconds;
    logic [SecW-1:0]   first_lamp_seconds;
    logic [PctW-1:0]   battery_warn_percent;
    logic              manual_mode;
  } cfg_t;

  typedef struct packed {
    logic [LevelW-1:0] light_level;
    logic              open_switch;
    logic              closed_switch;
    logic [PctW-1:0]   battery_percent;
    logic              external_power;
  } tick_t;

  typedef struct packed {
    logic [1:0] motor_drive;
    logic       lamp;
    logic [2:0] event_code;
  } result_t;

endpackage

/* hdl/ldc_cfg_regs.sv */
`timescale 1ns / 1ps

module ldc_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  input  logic [ldc_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [ldc_pkg::CfgDataW-1:0]    cfg_data_i,
  output ldc_pkg::cfg_t                   cfg_o
);

  ldc_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.open_brightness      <= 12'd10;
      cfg_q.close_brightness     <= 12'd3;
      cfg_q.qualify_seconds      <= 8'd15;
      cfg_q.close_delay_minutes  <= 10'd45;
      cfg_q.lamp_seconds         <= 17'd48600;
      cfg_q.first_lamp_seconds   <= 17'd12600;
      cfg_q.battery_warn_percent <= 7'd20;
      cfg_q.manual_mode          <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        ldc_pkg::REG_OPEN_BRIGHT:  cfg_q.open_brightness <= cfg_data_i[ldc_pkg::LevelW-1:0];
        ldc_pkg::REG_CLOSE_BRIGHT: cfg_q.close_brightness <= cfg_data_i[ldc_pkg::LevelW-1:0];
        ldc_pkg::REG_QUALIFY:      cfg_q.qualify_seconds <= cfg_data_i[ldc_pkg::QualW-1:0];
        ldc_pkg::REG_CLOSE_DELAY:  cfg_q.close_delay_minutes <= cfg_data_i[ldc_pkg::DelayW-1:0];
        ldc_pkg::REG_LAMP_SECS:    cfg_q.lamp_seconds <= cfg_data_i[ldc_pkg::SecW-1:0];
        ldc_pkg::REG_FIRST_LAMP:   cfg_q.first_lamp_seconds <= cfg_data_i[ldc_pkg::SecW-1:0];
        ldc_pkg::REG_BATT_WARN:    cfg_q.battery_warn_percent <= cfg_data_i[ldc_pkg::PctW-1:0];
        ldc_pkg::REG_MANUAL:       cfg_q.manual_mode <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* hdl/ldc_step.sv */
`timescale 1ns / 1ps

module ldc_step (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  ldc_pkg::tick_t   tick_i,
  input  ldc_pkg::cfg_t    cfg_i,
  output ldc_pkg::result_t res_o
);

  localparam logic [ldc_pkg::SecW-1:0]   SoMax  = {ldc_pkg::SecW{1'b1}};
  localparam logic [ldc_pkg::DuskW-1:0]  SdMax  = {ldc_pkg::DuskW{1'b1}};
  localparam logic [ldc_pkg::TimerW-1:0] TmMax  = {ldc_pkg::TimerW{1'b1}};
  localparam logic [ldc_pkg::TimerW-1:0] TmOut  =
    ldc_pkg::TimerW'(ldc_pkg::MotorTimeoutSeconds);
  localparam logic [ldc_pkg::DuskW-1:0]  MinSecs =
    ldc_pkg::DuskW'(ldc_pkg::SecsPerMinute);

  logic [ldc_pkg::QualW-1:0]  dark_count_q, dark_count_d;
  logic [ldc_pkg::QualW-1:0]  light_count_q, light_count_d;
  logic                       dusk_pending_q, dusk_pending_d;
  logic [ldc_pkg::DuskW-1:0]  since_dusk_q, since_dusk_d;
  logic [ldc_pkg::SecW-1:0]   since_open_q, since_open_d;
  logic                       ever_opened_q, ever_opened_d;
  logic [1:0]                 phase_q, phase_d;
  logic [ldc_pkg::TimerW-1:0] timer_q, timer_d;
  logic                       lamp_on_q, lamp_on_d;
  logic                       close_failed_q, close_failed_d;
  logic                       batt_warned_q, batt_warned_d;

  logic [ldc_pkg::DuskW-1:0] delay_secs;
  logic [ldc_pkg::PctW:0]    batt_release;
  logic                      do_close, close_ok, dark, light;
  logic [1:0]                drive;
  logic [2:0]                ev;

  // delay*60 tops out at 61380, inside 16 bits
  assign delay_secs   = ldc_pkg::DuskW'(cfg_i.close_delay_minutes) * MinSecs;
  assign batt_release = {1'b0, cfg_i.battery_warn_percent} +
                        (ldc_pkg::PctW+1)'(ldc_pkg::BattHysteresis);

  always_comb begin
    dark_count_d   = dark_count_q;
    light_count_d  = light_count_q;
    dusk_pending_d = dusk_pending_q;
    since_dusk_d   = since_dusk_q;
    since_open_d   = since_open_q;
    ever_opened_d  = ever_opened_q;
    phase_d        = phase_q;
    timer_d        = timer_q;
    lamp_on_d      = lamp_on_q;
    close_failed_d = close_failed_q;
    batt_warned_d  = batt_warned_q;
    do_close       = 1'b0;
    close_ok       = 1'b0;
    drive          = ldc_pkg::DRV_RELEASE;
    ev             = ldc_pkg::EV_NONE;
    dark           = 1'b0;
    light          = 1'b0;

    if (ever_opened_q && since_open_q != SoMax) since_open_d = since_open_q + 1'b1;
    if (dusk_pending_q && since_dusk_q != SdMax) since_dusk_d = since_dusk_q + 1'b1;
    if (lamp_on_q && since_open_d > cfg_i.lamp_seconds) lamp_on_d = 1'b0;

    if (phase_q != ldc_pkg::PH_IDLE) begin
      dark_count_d  = '0;
      light_count_d = '0;
      if (timer_q != TmMax) timer_d = timer_q + 1'b1;
      unique case (phase_q)
        ldc_pkg::PH_CLOSE: begin
          if (tick_i.closed_switch) begin
            do_close = 1'b1;
            close_ok = 1'b1;
          end else if (tick_i.open_switch) begin
            phase_d = ldc_pkg::PH_UNWIND;
            timer_d = '0;
            drive   = ldc_pkg::DRV_BACKWARD;
          end else if (timer_d >= TmOut) begin
            do_close = 1'b1;
          end else begin
            drive = ldc_pkg::DRV_FORWARD;
          end
        end
        ldc_pkg::PH_UNWIND: begin
          if (tick_i.closed_switch) begin
            do_close = 1'b1;
            close_ok = 1'b1;
          end else if (tick_i.open_switch || timer_d >= TmOut) begin
            do_close = 1'b1;
          end else begin
            drive = ldc_pkg::DRV_BACKWARD;
          end
        end
        default: begin
          if (tick_i.open_switch) begin
            ev      = ldc_pkg::EV_OPENED;
            phase_d = ldc_pkg::PH_IDLE;
            timer_d = '0;
          end else if (timer_d >= TmOut) begin
            ev      = ldc_pkg::EV_OPEN_FAIL;
            phase_d = ldc_pkg::PH_IDLE;
            timer_d = '0;
          end else begin
            drive = ldc_pkg::DRV_BACKWARD;
          end
        end
      endcase
    end else if (dusk_pending_q && !tick_i.closed_switch && !cfg_i.manual_mode &&
                 since_dusk_d > delay_secs) begin
      dark_count_d  = '0;
      light_count_d = '0;
      phase_d       = ldc_pkg::PH_CLOSE;
      timer_d       = '0;
      drive         = ldc_pkg::DRV_FORWARD;
    end else begin
      dark  = !dusk_pending_q && !tick_i.closed_switch && !cfg_i.manual_mode &&
              tick_i.light_level < cfg_i.close_brightness;
      light = !tick_i.open_switch && !cfg_i.manual_mode &&
              tick_i.light_level > cfg_i.open_brightness;
      if (dark) begin
        light_count_d = '0;
        if (dark_count_q >= cfg_i.qualify_seconds) begin
          dark_count_d   = '0;
          dusk_pending_d = 1'b1;
          since_dusk_d   = '0;
          ev             = ldc_pkg::EV_DUSK;
        end else begin
          dark_count_d = dark_count_q + 1'b1;
        end
      end else if (light) begin
        dark_count_d = '0;
        if (light_count_q >= cfg_i.qualify_seconds) begin
          light_count_d  = '0;
          phase_d        = ldc_pkg::PH_OPEN;
          timer_d        = '0;
          since_open_d   = '0;
          ever_opened_d  = 1'b1;
          dusk_pending_d = 1'b0;
          since_dusk_d   = '0;
          drive          = ldc_pkg::DRV_BACKWARD;
        end else begin
          light_count_d = light_count_q + 1'b1;
        end
      end else begin
        dark_count_d  = '0;
        light_count_d = '0;
      end
    end

    // end of a close run, good or bad
    if (do_close) begin
      if (!ever_opened_q) begin
        since_open_d  = (cfg_i.lamp_seconds > cfg_i.first_lamp_seconds) ?
                        cfg_i.lamp_seconds - cfg_i.first_lamp_seconds : '0;
        ever_opened_d = 1'b1;
      end
      phase_d = ldc_pkg::PH_IDLE;
      timer_d = '0;
      if (close_ok) begin
        dusk_pending_d = 1'b0;
        close_failed_d = 1'b0;
        if (since_open_d < cfg_i.lamp_seconds) lamp_on_d = 1'b1;
        ev = ldc_pkg::EV_CLOSED;
      end else if (!close_failed_q) begin
        close_failed_d = 1'b1;
        ev             = ldc_pkg::EV_CLOSE_FAIL;
      end
    end

    // battery low waits for a tick with no other event
    if (!tick_i.external_power) begin
      if (tick_i.battery_percent < cfg_i.battery_warn_percent && !batt_warned_q &&
          ev == ldc_pkg::EV_NONE) begin
        ev            = ldc_pkg::EV_BATTERY_LOW;
        batt_warned_d = 1'b1;
      end
      if ({1'b0, tick_i.battery_percent} > batt_release && batt_warned_d) begin
        batt_warned_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dark_count_q   <= '0;
      light_count_q  <= '0;
      dusk_pending_q <= 1'b0;
      since_dusk_q   <= '0;
      since_open_q   <= '0;
      ever_opened_q  <= 1'b0;
      phase_q        <= ldc_pkg::PH_IDLE;
      timer_q        <= '0;
      lamp_on_q      <= 1'b0;
      close_failed_q <= 1'b0;
      batt_warned_q  <= 1'b0;
    end else if (step_i) begin
      dark_count_q   <= dark_count_d;
      light_count_q  <= light_count_d;
      dusk_pending_q <= dusk_pending_d;
      since_dusk_q   <= since_dusk_d;
      since_open_q   <= since_open_d;
      ever_opened_q  <= ever_opened_d;
      phase_q        <= phase_d;
      timer_q        <= timer_d;
      lamp_on_q      <= lamp_on_d;
      close_failed_q <= close_failed_d;
      batt_warned_q  <= batt_warned_d;
    end
  end

  assign res_o.motor_drive = drive;
  assign res_o.lamp        = lamp_on_d;
  assign res_o.event_code  = ev;

endmodule

/* hdl/light_qualified_door_controller_core.sv */
`timescale 1ns / 1ps
// Channel   Direction  Handshake                     Payload
// s_axis    in         s_axis_tvalid/s_axis_tready   one tick sample
// m_axis    out        m_axis_tvalid/m_axis_tready   motor, lamp, event
// cfg       in         cfg_valid_i/cfg_ready_o       register index, data
//
// One tick per clock sustained while m_axis is not stalled; a beat passes through
// the input register, then the state update into the result register.
// Reset clears all door state and loads the register defaults.
// A stall on m_axis holds the result; s_axis keeps taking beats until both
// the input and the result register are full.

module light_qualified_door_controller_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [11:0] light_level, [12] open_switch, [13] closed_switch,
  // [20:14] battery_percent, [21] external_power, [23:22] zero
  input  logic [ldc_pkg::InDataW-1:0]   s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [1:0] motor_drive, [2] lamp, [5:3] event_code, [7:6] zero
  output logic [ldc_pkg::OutDataW-1:0]  m_axis_tdata,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ldc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [ldc_pkg::CfgDataW-1:0]  cfg_data_i
);

  ldc_pkg::cfg_t    cfg;
  ldc_pkg::tick_t   tick_q;
  ldc_pkg::result_t res, res_q;
  logic             in_valid_q, out_valid_q, advance;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign cfg_ready_o   = 1'b1;

  ldc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  ldc_step u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .tick_i (tick_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) in_valid_q <= s_axis_tvalid;
      if (advance) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      tick_q.light_level     <= s_axis_tdata[11:0];
      tick_q.open_switch     <= s_axis_tdata[12];
      tick_q.closed_switch   <= s_axis_tdata[13];
      tick_q.battery_percent <= s_axis_tdata[20:14];
      tick_q.external_power  <= s_axis_tdata[21];
    end
    if (advance) res_q <= res;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, res_q.event_code, res_q.lamp, res_q.motor_drive};

endmodule

/* hdl/ldc_checker.sv */
`timescale 1ns / 1ps

module ldc_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [ldc_pkg::OutDataW-1:0]  m_axis_tdata,
  input logic                          cfg_ready_o
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed under stall");

  a_drive_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[1:0] != ldc_pkg::DRV_ILLEGAL)
    else $error("illegal motor drive");

  a_event_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[5:3] != ldc_pkg::EV_ILLEGAL)
    else $error("illegal event code");

  // a drive command never comes with a motor completion event
  a_drive_vs_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[1:0] != ldc_pkg::DRV_RELEASE |->
      m_axis_tdata[5:3] != ldc_pkg::EV_CLOSED && m_axis_tdata[5:3] != ldc_pkg::EV_OPENED &&
      m_axis_tdata[5:3] != ldc_pkg::EV_CLOSE_FAIL && m_axis_tdata[5:3] != ldc_pkg::EV_OPEN_FAIL)
    else $error("motor driven on a completion beat");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("configuration port not ready");

endmodule

bind light_qualified_door_controller_core ldc_checker u_ldc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .cfg_ready_o   (cfg_ready_o)
);
